// ===== rtl/ismc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_pkg
// Shared types, request codes, status codes and register addresses of the
// interrupt status and mask controller.
// ----------------------------------------------------------------------------
package ismc_pkg;

    // Default line counts.
    localparam int NUM_CAUSES_DEF   = 15;
    localparam int NUM_CHANNELS_DEF = 10;

    // Request codes carried in the mode field.
    localparam logic [2:0] MODE_RAISE   = 3'd0;
    localparam logic [2:0] MODE_READ    = 3'd1;
    localparam logic [2:0] MODE_WRITE   = 3'd2;
    localparam logic [2:0] MODE_MASK    = 3'd3;
    localparam logic [2:0] MODE_ENABLE  = 3'd4;
    localparam logic [2:0] MODE_DELIVER = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SERVED  = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // Bus register addresses.
    localparam logic [31:0] ADDR_ISTAT = 32'h1000_F000;
    localparam logic [31:0] ADDR_IMASK = 32'h1000_F010;
    localparam logic [31:0] ADDR_DSTAT = 32'h1000_E010;

    // Bit position of the channel mask inside D_STAT.
    localparam int DSTAT_MASK_LSB = 16;

    // Request word.
    typedef struct packed {
        logic [2:0]  mode;
        logic        bank;
        logic [4:0]  line;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        flag;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic        changed;
        logic        served_bank;
        logic [3:0]  served_line;
        logic        irq_pending;
        logic        last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic exec_single;
        logic start_walk;
        logic step_walk;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic deliver_go;
        logic walk_last;
    } t_dp_stat;

endpackage : ismc_pkg
`default_nettype wire

// ===== rtl/ismc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_ctrl
// Sequencer: takes one request word, runs it once, and for a deliver
// steps through the captured pending lines, one result word per cycle while the output is free.
// ----------------------------------------------------------------------------
module ismc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ismc_pkg::t_dp_stat i_stat,
    output ismc_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state          = r_state;
        n_in_ready       = r_in_ready;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                    n_in_ready     = 1'b0;
                end
            end
            S_EXEC: begin
                if (i_stat.deliver_go) begin
                    o_cmd.start_walk = 1'b1;
                    n_state          = S_WALK;
                end else if (i_stat.out_free) begin
                    o_cmd.exec_single = 1'b1;
                    n_state           = S_IDLE;
                    n_in_ready        = 1'b1;
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.step_walk = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state    = S_IDLE;
                        n_in_ready = 1'b1;
                    end
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule : ismc_ctrl
`default_nettype wire

// ===== rtl/ismc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_datapath
// Status, mask and enable registers, the request holding register, the
// deliver snapshot with its lowest-line search, and the result register.
// ----------------------------------------------------------------------------
module ismc_datapath #(
    parameter int NUM_CAUSES   = ismc_pkg::NUM_CAUSES_DEF,
    parameter int NUM_CHANNELS = ismc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ismc_pkg::t_in_word  i_in_data,
    input  wire ismc_pkg::t_dp_cmd   i_cmd,
    output ismc_pkg::t_dp_stat       o_stat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ismc_pkg::t_out_word      o_out_data
);

    localparam int SNAP_W = NUM_CAUSES + NUM_CHANNELS;
    localparam int IDX_W  = $clog2(SNAP_W);

    // Architectural state.
    logic [NUM_CAUSES-1:0]   r_cs, n_cs;
    logic [NUM_CAUSES-1:0]   r_cm, n_cm;
    logic [NUM_CHANNELS-1:0] r_chs, n_chs;
    logic [NUM_CHANNELS-1:0] r_chm, n_chm;
    logic                    r_en, n_en;

    // Request, snapshot and result registers.
    ismc_pkg::t_in_word  r_req;
    logic [SNAP_W-1:0]   r_snap;
    ismc_pkg::t_out_word r_out, n_out;
    logic                r_out_valid;

    // Request decode.
    logic                    line_ok;
    logic [NUM_CAUSES-1:0]   c_bit;
    logic [NUM_CHANNELS-1:0] ch_bit;
    logic [NUM_CAUSES-1:0]   ip;
    logic [NUM_CHANNELS-1:0] dp;
    logic [1:0]              res_status;
    logic [31:0]             res_rd;
    logic                    res_chg;
    logic                    was_set;
    logic                    pend_next;
    logic                    pend_cur;

    // Snapshot search.
    logic [SNAP_W-1:0] snap_low;
    logic [IDX_W-1:0]  snap_idx;
    logic [5:0]        idx_ext;
    logic [5:0]        walk_line;
    logic              walk_bank;

    assign line_ok = r_req.bank ? (r_req.line < 5'(NUM_CHANNELS))
                                : (r_req.line < 5'(NUM_CAUSES));
    assign c_bit   = NUM_CAUSES'(1) << r_req.line;
    assign ch_bit  = NUM_CHANNELS'(1) << r_req.line;
    assign ip      = r_cs & r_cm;
    assign dp      = r_chs & r_chm;
    assign was_set = |(r_cm & c_bit);

    // Single-word request: next state and result fields.
    always_comb begin
        n_cs       = r_cs;
        n_cm       = r_cm;
        n_chs      = r_chs;
        n_chm      = r_chm;
        n_en       = r_en;
        res_status = ismc_pkg::ST_DONE;
        res_rd     = '0;
        res_chg    = 1'b0;
        case (r_req.mode)
            ismc_pkg::MODE_RAISE: begin
                if (!line_ok) begin
                    res_status = ismc_pkg::ST_INVALID;
                end else if (r_req.bank) begin
                    n_chs = r_chs | ch_bit;
                end else begin
                    n_cs = r_cs | c_bit;
                end
            end
            ismc_pkg::MODE_READ: begin
                if (r_req.address == ismc_pkg::ADDR_ISTAT) begin
                    res_rd = 32'(r_cs);
                end else if (r_req.address == ismc_pkg::ADDR_IMASK) begin
                    res_rd = 32'(r_cm);
                end else if (r_req.address == ismc_pkg::ADDR_DSTAT) begin
                    res_rd = 32'(r_chs) | (32'(r_chm) << ismc_pkg::DSTAT_MASK_LSB);
                end else begin
                    res_status = ismc_pkg::ST_INVALID;
                end
            end
            ismc_pkg::MODE_WRITE: begin
                // Status bits clear on a one; mask bits toggle on a one.
                if (r_req.address == ismc_pkg::ADDR_ISTAT) begin
                    n_cs = r_cs & ~r_req.write_data[NUM_CAUSES-1:0];
                end else if (r_req.address == ismc_pkg::ADDR_IMASK) begin
                    n_cm = r_cm ^ r_req.write_data[NUM_CAUSES-1:0];
                end else if (r_req.address == ismc_pkg::ADDR_DSTAT) begin
                    n_chs = r_chs & ~r_req.write_data[NUM_CHANNELS-1:0];
                    n_chm = r_chm ^
                        r_req.write_data[ismc_pkg::DSTAT_MASK_LSB +: NUM_CHANNELS];
                end else begin
                    res_status = ismc_pkg::ST_INVALID;
                end
            end
            ismc_pkg::MODE_MASK: begin
                if (!line_ok) begin
                    res_status = ismc_pkg::ST_INVALID;
                end else if (r_req.bank) begin
                    n_chm   = r_req.flag ? (r_chm | ch_bit) : (r_chm & ~ch_bit);
                    res_chg = 1'b1;
                end else begin
                    n_cm    = r_req.flag ? (r_cm | c_bit) : (r_cm & ~c_bit);
                    res_chg = r_req.flag ? !was_set : was_set;
                end
            end
            ismc_pkg::MODE_ENABLE: begin
                n_en = r_req.flag;
            end
            ismc_pkg::MODE_DELIVER: begin
                // Only reached here when nothing is to be delivered.
                res_status = ismc_pkg::ST_NONE;
            end
            default: begin
                res_status = ismc_pkg::ST_INVALID;
            end
        endcase
    end

    assign pend_next = n_en && ((|(n_cs & n_cm)) || (|(n_chs & n_chm)));
    assign pend_cur  = r_en && ((|ip) || (|dp));

    // Lowest pending line of the snapshot; causes sit in the low bits.
    assign snap_low = r_snap & (~r_snap + SNAP_W'(1));

    always_comb begin
        snap_idx = '0;
        for (int i = 0; i < SNAP_W; i++) begin
            if (snap_low[i]) begin
                snap_idx = snap_idx | IDX_W'(i);
            end
        end
    end

    assign idx_ext   = 6'(snap_idx);
    assign walk_bank = (idx_ext >= 6'(NUM_CAUSES));
    assign walk_line = walk_bank ? (idx_ext - 6'(NUM_CAUSES)) : idx_ext;

    // Result word to load.
    always_comb begin
        n_out = '0;
        if (i_cmd.step_walk) begin
            n_out.status      = ismc_pkg::ST_SERVED;
            n_out.served_bank = walk_bank;
            n_out.served_line = walk_line[3:0];
            n_out.irq_pending = pend_cur;
            n_out.last        = ((r_snap & ~snap_low) == '0);
        end else begin
            n_out.status      = res_status;
            n_out.read_data   = res_rd;
            n_out.changed     = res_chg;
            n_out.irq_pending = pend_next;
            n_out.last        = 1'b1;
        end
    end

    // Architectural state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs  <= '0;
            r_cm  <= '0;
            r_chs <= '0;
            r_chm <= '0;
            r_en  <= 1'b1;
        end else if (i_cmd.exec_single) begin
            r_cs  <= n_cs;
            r_cm  <= n_cm;
            r_chs <= n_chs;
            r_chm <= n_chm;
            r_en  <= n_en;
        end else if (i_cmd.start_walk) begin
            // Every captured line is cleared at once; the walk only reports.
            r_cs  <= r_cs & ~ip;
            r_chs <= r_chs & ~dp;
        end
    end

    // Request and snapshot registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
        end
        if (i_cmd.start_walk) begin
            r_snap <= {dp, ip};
        end else if (i_cmd.step_walk) begin
            r_snap <= r_snap & ~snap_low;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec_single || i_cmd.step_walk) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_single || i_cmd.step_walk) begin
            r_out <= n_out;
        end
    end

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.deliver_go = (r_req.mode == ismc_pkg::MODE_DELIVER) && pend_cur;
    assign o_stat.walk_last  = ((r_snap & ~snap_low) == '0);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule : ismc_datapath
`default_nettype wire

// ===== rtl/interrupt_status_mask_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_status_mask_controller_core
// Interrupt cause and DMA channel status/mask controller with bus register
// access and ordered delivery of pending lines.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Word type
//  --------  --------------------------  ---------------------
//  request   i_in_valid / o_in_ready     ismc_pkg::t_in_word
//  result    o_out_valid / i_out_ready   ismc_pkg::t_out_word
//
//  A request is captured, then executed, and gives one result word.
//  A deliver is captured, snapshots its pending lines, then gives one
//  result word per cycle, when the output is free, as the lines are walked.
//  The next request is taken once the last result word is loaded; output
//  stalls hold the sequencer. Reset is synchronous, active low, and leaves
//  delivery enabled with all status and mask bits clear.
//
module interrupt_status_mask_controller_core #(
    parameter int NUM_CAUSES   = ismc_pkg::NUM_CAUSES_DEF,
    parameter int NUM_CHANNELS = ismc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ismc_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ismc_pkg::t_out_word     o_out_data
);

    ismc_pkg::t_dp_cmd  cmd;
    ismc_pkg::t_dp_stat stat;

    // Sequencer.
    ismc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Registers and result datapath.
    ismc_datapath #(
        .NUM_CAUSES   (NUM_CAUSES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule : interrupt_status_mask_controller_core
`default_nettype wire
